// ===== rtl/core/bpel_pkg.sv =====
package bpel_pkg;

	localparam int FIFO_DEPTH = 128;
	localparam int TIME_BITS  = 32;

	localparam int PTR_W   = $clog2(FIFO_DEPTH);
	localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
	localparam int ENTRY_W = TIME_BITS + 1;

	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	// register indexes, taken from paddr[5:3]
	localparam logic [2:0] REG_ID_A_HIGH       = 3'd0;
	localparam logic [2:0] REG_ID_A_LOW        = 3'd1;
	localparam logic [2:0] REG_ID_B_HIGH       = 3'd2;
	localparam logic [2:0] REG_ID_B_LOW        = 3'd3;
	localparam logic [2:0] REG_ABSENCE_TIMEOUT = 3'd4;
	localparam logic [2:0] REG_POST_INTERVAL   = 3'd5;

	localparam logic [15:0] ABSENCE_TIMEOUT_RST = 16'd5;
	localparam logic [15:0] POST_INTERVAL_RST   = 16'd20;

	localparam logic [7:0] ELEM_TYPE_MFR = 8'hFF;
	localparam logic [7:0] ELEM_MIN_LEN  = 8'd21;

	localparam logic FUNC_TICK    = 1'b0;
	localparam logic FUNC_ELEMENT = 1'b1;

	// last queued event state
	localparam logic [1:0] LAST_OFF  = 2'd0;
	localparam logic [1:0] LAST_ON   = 2'd1;
	localparam logic [1:0] LAST_NONE = 2'd2;

	typedef struct packed {
		logic        func;
		logic [31:0] now_seconds;
		logic [7:0]  element_type;
		logic [7:0]  element_length;
		logic [63:0] id_high;
		logic [63:0] id_low;
	} in_t;

	typedef struct packed {
		logic        relay_on;
		logic        post_valid;
		logic        post_state;
		logic [31:0] post_time;
		logic        push_dropped_full;
		logic [7:0]  queued_count;
	} out_t;

	typedef struct packed {
		logic [63:0] id_a_high;
		logic [63:0] id_a_low;
		logic [63:0] id_b_high;
		logic [63:0] id_b_low;
		logic [15:0] absence_timeout;
		logic [15:0] post_interval;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic eval;
		logic pop;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

// ===== rtl/core/bpel_regs.sv =====
module bpel_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bpel_pkg::ADDR_W-1:0]  paddr,
	input  logic [bpel_pkg::DATA_W-1:0]  pwdata,
	output logic [bpel_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output bpel_pkg::cfg_t               cfg
);

	bpel_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     idx;

	assign idx    = paddr[5:3];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.id_a_high       <= '0;
			cfg_q.id_a_low        <= '0;
			cfg_q.id_b_high       <= '0;
			cfg_q.id_b_low        <= '0;
			cfg_q.absence_timeout <= bpel_pkg::ABSENCE_TIMEOUT_RST;
			cfg_q.post_interval   <= bpel_pkg::POST_INTERVAL_RST;
		end else if (wr_en) begin
			unique case (idx)
				bpel_pkg::REG_ID_A_HIGH:       cfg_q.id_a_high <= pwdata;
				bpel_pkg::REG_ID_A_LOW:        cfg_q.id_a_low  <= pwdata;
				bpel_pkg::REG_ID_B_HIGH:       cfg_q.id_b_high <= pwdata;
				bpel_pkg::REG_ID_B_LOW:        cfg_q.id_b_low  <= pwdata;
				bpel_pkg::REG_ABSENCE_TIMEOUT: cfg_q.absence_timeout <= pwdata[15:0];
				bpel_pkg::REG_POST_INTERVAL:   cfg_q.post_interval   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			bpel_pkg::REG_ID_A_HIGH:       prdata = cfg_q.id_a_high;
			bpel_pkg::REG_ID_A_LOW:        prdata = cfg_q.id_a_low;
			bpel_pkg::REG_ID_B_HIGH:       prdata = cfg_q.id_b_high;
			bpel_pkg::REG_ID_B_LOW:        prdata = cfg_q.id_b_low;
			bpel_pkg::REG_ABSENCE_TIMEOUT: prdata = {48'd0, cfg_q.absence_timeout};
			bpel_pkg::REG_POST_INTERVAL:   prdata = {48'd0, cfg_q.post_interval};
			default:                       prdata = '0;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && idx == bpel_pkg::REG_ABSENCE_TIMEOUT)
		|=> cfg_q.absence_timeout == $past(pwdata[15:0]))
		else $error("absence timeout write lost");

	assert property (@(posedge clk) disable iff (!arst_n)
		!wr_en |=> $stable(cfg_q))
		else $error("configuration changed without a write");

	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && idx == bpel_pkg::REG_ID_B_LOW) |=> cfg_q.id_b_low == $past(pwdata))
		else $error("id_b_low write lost");

endmodule

// ===== rtl/core/bpel_ctrl.sv =====
module bpel_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  bpel_pkg::status_t status,
	output bpel_pkg::cmd_t    cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_POP;
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				// hold until the result register can take the item
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> state_q == S_EVAL)
		else $error("accepted item not evaluated");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |=> state_q == S_POP)
		else $error("pop phase skipped");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && status.out_free) |=> state_q == S_IDLE)
		else $error("result not released");

endmodule

// ===== rtl/core/bpel_datapath.sv =====
module bpel_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  bpel_pkg::cfg_t    cfg,
	input  bpel_pkg::cmd_t    cmd,
	output bpel_pkg::status_t status,
	input  bpel_pkg::in_t     item,
	output logic              result_valid,
	input  logic              result_ready,
	output bpel_pkg::out_t    result
);

	localparam int TB = bpel_pkg::TIME_BITS;
	localparam int PW = bpel_pkg::PTR_W;
	localparam int CW = bpel_pkg::CNT_W;

	bpel_pkg::in_t   in_s1;
	logic [TB-1:0]   now;

	logic [TB-1:0]   last_seen_q;
	logic [TB-1:0]   last_post_q;
	logic            posted_once_q;
	logic            relay_q;
	logic [1:0]      last_q;
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            dropped_q;
	logic            popped_q;

	logic [bpel_pkg::ENTRY_W-1:0] mem [bpel_pkg::FIFO_DEPTH];
	logic [bpel_pkg::ENTRY_W-1:0] rd_data_q;

	logic            id_match;
	logic            match;
	logic            timeout;
	logic            push_req;
	logic            push_st;
	logic            full;
	logic            push_go;
	logic            pop_go;
	logic [TB-1:0]   seen_diff;
	logic [TB-1:0]   post_diff;

	bpel_pkg::out_t  out_q;
	logic            out_valid_q;

	assign now = TB'(in_s1.now_seconds);

	assign id_match = (in_s1.id_high == cfg.id_a_high && in_s1.id_low == cfg.id_a_low) ||
			(in_s1.id_high == cfg.id_b_high && in_s1.id_low == cfg.id_b_low);
	assign match = (in_s1.func == bpel_pkg::FUNC_ELEMENT) &&
			(in_s1.element_type == bpel_pkg::ELEM_TYPE_MFR) &&
			(in_s1.element_length >= bpel_pkg::ELEM_MIN_LEN) && id_match;

	assign seen_diff = now - last_seen_q;
	assign timeout   = (in_s1.func == bpel_pkg::FUNC_TICK) && (last_seen_q != '0) &&
			(seen_diff >= TB'(cfg.absence_timeout));

	assign push_req = match || timeout;
	assign push_st  = match;
	assign full     = (cnt_q == CW'(bpel_pkg::FIFO_DEPTH));
	// drop a repeat of the last queued state
	assign push_go  = cmd.eval && push_req && !full &&
			(last_q != (push_st ? bpel_pkg::LAST_ON : bpel_pkg::LAST_OFF));

	assign post_diff = now - last_post_q;
	assign pop_go    = cmd.pop && (in_s1.func == bpel_pkg::FUNC_TICK) && (cnt_q != '0) &&
			(!posted_once_q || post_diff > TB'(cfg.post_interval));

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_s1 <= item;
		end
	end

	always_ff @(posedge clk) begin
		if (push_go) begin
			mem[wr_ptr_q] <= {push_st, now};
		end
	end

	always_ff @(posedge clk) begin
		if (pop_go) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seen_q   <= '0;
			last_post_q   <= '0;
			posted_once_q <= 1'b0;
			relay_q       <= 1'b0;
			last_q        <= bpel_pkg::LAST_NONE;
			wr_ptr_q      <= '0;
			rd_ptr_q      <= '0;
			cnt_q         <= '0;
			dropped_q     <= 1'b0;
			popped_q      <= 1'b0;
		end else begin
			if (cmd.eval) begin
				dropped_q <= push_req && full;
				if (match) begin
					last_seen_q <= now;
					relay_q     <= 1'b1;
				end else if (timeout) begin
					last_seen_q <= '0;
					relay_q     <= 1'b0;
				end
			end
			if (push_go) begin
				last_q   <= push_st ? bpel_pkg::LAST_ON : bpel_pkg::LAST_OFF;
				wr_ptr_q <= (wr_ptr_q == PW'(bpel_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd.pop) begin
				popped_q <= pop_go;
			end
			if (pop_go) begin
				rd_ptr_q      <= (rd_ptr_q == PW'(bpel_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
				posted_once_q <= 1'b1;
				last_post_q   <= now;
			end
			if (push_go) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_go) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign status.out_free = !out_valid_q || result_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.relay_on          <= relay_q;
			out_q.post_valid        <= popped_q;
			out_q.post_state        <= popped_q && rd_data_q[TB];
			out_q.post_time         <= popped_q ? 32'(rd_data_q[TB-1:0]) : 32'd0;
			out_q.push_dropped_full <= dropped_q;
			out_q.queued_count      <= 8'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(bpel_pkg::FIFO_DEPTH))
		else $error("event count beyond FIFO depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop_go |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("pop did not reduce the count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.eval && match) |=> relay_q)
		else $error("relay not switched on after a sighting");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && !status.out_free) == 1'b0)
		else $error("result register overwritten");

endmodule

// ===== rtl/core/beacon_presence_event_logger_core.sv =====
// An accepted item passes the evaluate, pop and load-result states in turn; the load
// waits until the output register is free. The four-state controller handles one item
// at a time, and the event FIFO read is registered, so a pop has a state of its own.
// A finished result waits in the output register while the next item is taken.
// Reset (arst_n low) clears pointers, count, relay and post state; registers take
// their reset values. FIFO storage is not cleared and needs no clearing pass.
module beacon_presence_event_logger_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  bpel_pkg::in_t                item,
	output logic                         result_valid,
	input  logic                         result_ready,
	output bpel_pkg::out_t               result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bpel_pkg::ADDR_W-1:0]  paddr,
	input  logic [bpel_pkg::DATA_W-1:0]  pwdata,
	output logic [bpel_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	bpel_pkg::cfg_t    cfg;
	bpel_pkg::cmd_t    cmd;
	bpel_pkg::status_t status;

	bpel_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bpel_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	bpel_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.status       (status),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
